FILE: rtl/ifr_pkg.sv
// Shared types and constants for the IMU frame receiver and tilt monitor.
package ifr_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned FRAME_LEN_DEF = 7;

  // Byte positions inside a frame
  localparam int unsigned HDR_POS   = 0;
  localparam int unsigned YAW_POS   = 1;
  localparam int unsigned ROLL_POS  = 3;
  localparam int unsigned ACCEL_POS = 5;

  // Config register file
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_MASK_RST    = 8'hFC;
  localparam logic [BYTE_W-1:0] SYNC_PATTERN_RST = 8'h78;
  localparam logic [WORD_W-1:0] RAMP_LIMIT_RST   = 16'd17;
  localparam logic [TICK_W-1:0] STABLE_TIME_RST  = 32'd2000;

  typedef enum logic [1:0] {
    REG_SYNC_MASK    = 2'd0,
    REG_SYNC_PATTERN = 2'd1,
    REG_RAMP_LIMIT   = 2'd2,
    REG_STABLE_TIME  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_mask;
    logic [BYTE_W-1:0] sync_pattern;
    logic [WORD_W-1:0] ramp_limit;
    logic [TICK_W-1:0] stable_time;
  } cfg_t;

  // Per-cycle control broadcast to the byte cells
  typedef struct packed {
    logic shift;   // accepted byte moves one cell along
    logic latch;   // frame complete: every cell captures its input
  } cell_ctrl_t;

endpackage

FILE: rtl/ifr_cell.sv
// One byte cell of the frame chain: assembly stage plus latched copy.
module ifr_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ifr_pkg::cell_ctrl_t        ctrl_i,
  input  logic [ifr_pkg::BYTE_W-1:0] din_i,
  output logic [ifr_pkg::BYTE_W-1:0] sh_o,
  output logic [ifr_pkg::BYTE_W-1:0] lt_o,
  output logic                       diff_o
);
  import ifr_pkg::*;

  logic [BYTE_W-1:0] sh_q, sh_d;
  logic [BYTE_W-1:0] lt_q, lt_d;

  always_comb begin
    sh_d = ctrl_i.shift ? din_i : sh_q;
    lt_d = ctrl_i.latch ? din_i : lt_q;
  end

  // assembly stage holds no reset: each position is written before a latch
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
    end else begin
      lt_q <= lt_d;
    end
  end

  assign sh_o   = sh_q;
  assign lt_o   = lt_q;
  // incoming frame byte differs from the one held
  assign diff_o = (din_i != lt_q);

endmodule

FILE: rtl/ifr_cfg.sv
// APB-style configuration registers for the frame receiver.
module ifr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ifr_pkg::PADDR_W-1:0] paddr,
  input  logic [ifr_pkg::PDATA_W-1:0] pwdata,
  output logic [ifr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ifr_pkg::cfg_t               cfg_o
);
  import ifr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SYNC_MASK:    cfg_d.sync_mask    = pwdata[BYTE_W-1:0];
        REG_SYNC_PATTERN: cfg_d.sync_pattern = pwdata[BYTE_W-1:0];
        REG_RAMP_LIMIT:   cfg_d.ramp_limit   = pwdata[WORD_W-1:0];
        REG_STABLE_TIME:  cfg_d.stable_time  = pwdata[TICK_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SYNC_MASK:    prdata = PDATA_W'(cfg_q.sync_mask);
      REG_SYNC_PATTERN: prdata = PDATA_W'(cfg_q.sync_pattern);
      REG_RAMP_LIMIT:   prdata = PDATA_W'(cfg_q.ramp_limit);
      REG_STABLE_TIME:  prdata = PDATA_W'(cfg_q.stable_time);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_mask    <= SYNC_MASK_RST;
      cfg_q.sync_pattern <= SYNC_PATTERN_RST;
      cfg_q.ramp_limit   <= RAMP_LIMIT_RST;
      cfg_q.stable_time  <= STABLE_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/imu_frame_receiver_tilt_monitor.sv
// Top level of the IMU frame receiver and tilt monitor.
// Each input item is either a serial byte (mode 0) or a time tick (mode 1), and
// every accepted item produces exactly one registered result item, which
// carries the latched yaw, roll and acceleration, the two header contact bits,
// the ramp flag, the calibrated flag and frame_done. A byte whose bits under
// sync_mask equal sync_pattern starts a frame; the following FRAME_LEN-1 bytes
// complete it, whereupon the whole frame is latched at once. Bytes travel down
// a row of FRAME_LEN byte cells, one cell per frame byte; on the last byte
// every cell captures its input into a latched copy and reports whether it
// changed, which clears the stability counter if yaw or roll moved. Items are
// taken one per clock unless stalled: the result sits in a single output stage
// and the input is stalled only while that stage is full and the output is
// stalled, so throughput is one item per cycle while the output flows.
// Configuration is through the APB-style port (registers at byte addresses
// 0, 4, 8, 12: sync_mask, sync_pattern, ramp_limit, stable_time) and must only
// be written while no result is outstanding.
module imu_frame_receiver_tilt_monitor #(
  parameter int unsigned FRAME_LEN = ifr_pkg::FRAME_LEN_DEF  // 7 to 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [ifr_pkg::BYTE_W-1:0]  rx_byte_i,
  // result item channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ifr_pkg::WORD_W-1:0]  yaw_o,
  output logic [ifr_pkg::WORD_W-1:0]  roll_o,
  output logic [ifr_pkg::WORD_W-1:0]  accel_o,
  output logic                        left_contact_o,
  output logic                        right_contact_o,
  output logic                        on_ramp_o,
  output logic                        calibrated_o,
  output logic                        frame_done_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ifr_pkg::PADDR_W-1:0] paddr,
  input  logic [ifr_pkg::PDATA_W-1:0] pwdata,
  output logic [ifr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ifr_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
  // frame byte j lives in cell FRAME_LEN-1-j
  localparam int unsigned CELL_HDR   = FRAME_LEN - 1 - HDR_POS;
  localparam int unsigned CELL_YAW   = FRAME_LEN - 1 - YAW_POS;
  localparam int unsigned CELL_ROLL  = FRAME_LEN - 1 - ROLL_POS;
  localparam int unsigned CELL_ACCEL = FRAME_LEN - 1 - ACCEL_POS;

  cfg_t       cfg;
  cell_ctrl_t cell_ctrl;

  logic [BYTE_W-1:0] cell_din [FRAME_LEN];
  logic [BYTE_W-1:0] cell_sh  [FRAME_LEN];
  logic [BYTE_W-1:0] cell_lt  [FRAME_LEN];
  logic [FRAME_LEN-1:0] cell_diff;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic              out_valid_q, out_valid_d;
  logic              done_q, done_d;

  logic in_acc, byte_acc, tick_acc, sync_hit, hunting, yaw_roll_moved;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  ifr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Handshake: the output stage parts the two sides
  // ---------------------------------------------------------------------------
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign byte_acc   = in_acc & ~mode_i;
  assign tick_acc   = in_acc & mode_i;

  // ---------------------------------------------------------------------------
  // Frame sequencing
  // ---------------------------------------------------------------------------
  assign hunting   = (idx_q == '0);
  assign sync_hit  = ((rx_byte_i & cfg.sync_mask) == cfg.sync_pattern);

  always_comb begin
    cell_ctrl.shift = byte_acc & (~hunting | sync_hit);
    cell_ctrl.latch = byte_acc & (idx_q == LAST_IDX);
  end

  always_comb begin
    idx_d = idx_q;
    if (cell_ctrl.latch) begin
      idx_d = '0;
    end else if (cell_ctrl.shift) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Chain of byte cells; cell 0 takes the incoming byte
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_din[k] = rx_byte_i;
    end else begin : g_link
      assign cell_din[k] = cell_sh[k-1];
    end

    ifr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .din_i  (cell_din[k]),
      .sh_o   (cell_sh[k]),
      .lt_o   (cell_lt[k]),
      .diff_o (cell_diff[k])
    );
  end

  // yaw and roll occupy frame bytes 1 to 4, i.e. four adjacent cells
  assign yaw_roll_moved = |cell_diff[CELL_YAW:CELL_ROLL-1];

  // ---------------------------------------------------------------------------
  // Stability counter: saturating tick count, cleared on yaw/roll change
  // ---------------------------------------------------------------------------
  always_comb begin
    ticks_d = ticks_q;
    if (tick_acc && (ticks_q != '1)) begin
      ticks_d = ticks_q + 1'b1;
    end else if (cell_ctrl.latch && yaw_roll_moved) begin
      ticks_d = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    done_d      = done_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      done_d      = cell_ctrl.latch;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
    end
  end

  // State only moves on an accepted item, so the result fields read straight
  // from the latched cells and hold while the output is stalled.
  assign yaw_o           = {cell_lt[CELL_YAW],   cell_lt[CELL_YAW-1]};
  assign roll_o          = {cell_lt[CELL_ROLL],  cell_lt[CELL_ROLL-1]};
  assign accel_o         = {cell_lt[CELL_ACCEL], cell_lt[CELL_ACCEL-1]};
  assign left_contact_o  = cell_lt[CELL_HDR][0];
  assign right_contact_o = cell_lt[CELL_HDR][1];
  assign on_ramp_o       = (roll_o > cfg.ramp_limit);
  assign calibrated_o    = (ticks_q > cfg.stable_time);
  assign frame_done_o    = done_q;
  assign out_valid_o     = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("frame position beyond frame length");

  a_latch_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.latch |=> (idx_q == '0) && frame_done_o && out_valid_o)
    else $error("completed frame did not rewind and flag done");

  a_done_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (idx_q == '0))
    else $error("frame done reported while still assembling");

  a_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && (ticks_q != '1)) |=> (ticks_q == $past(ticks_q) + 1'b1))
    else $error("tick not counted");

  a_tick_keeps_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> $stable(idx_q) && !frame_done_o)
    else $error("tick disturbed frame assembly");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IMU frame receiver and tilt monitor.
module testbench;
  import ifr_pkg::*;

  localparam int FRAME_N      = FRAME_LEN_DEF;
  localparam int QUIET_LIMIT  = 1000;  // cycles with no transfer before giving up
  localparam int PRESSURE_AT  = 160;   // results taken before the long hold-off
  localparam int PRESSURE_LEN = 48;    // length of that hold-off in cycles

  // One input item: a serial byte, or a tick when tick is set
  typedef struct packed {
    logic              tick;
    logic [BYTE_W-1:0] data;
  } imu_item_t;

  // One result item, field order as the output ports
  typedef struct packed {
    logic [WORD_W-1:0] yaw;
    logic [WORD_W-1:0] roll;
    logic [WORD_W-1:0] accel;
    logic              left_ct;
    logic              right_ct;
    logic              ramp;
    logic              calib;
    logic              done;
  } tilt_reading_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                mode_i     = 1'b0;
  logic [BYTE_W-1:0]   rx_byte_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WORD_W-1:0]   yaw_o, roll_o, accel_o;
  logic                left_contact_o, right_contact_o, on_ramp_o, calibrated_o;
  logic                frame_done_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Stimulus and scoreboard
  imu_item_t     sensor_items[$];
  tilt_reading_t predicted_readings[$];
  int            queued_total = 0;
  int            results_seen = 0;
  int            fault_count  = 0;
  int            send_gap     = 0;
  int            stall_left   = 0;
  int            hold_left    = 0;
  int            quiet_cycles = 0;
  bit            pressure_done = 1'b0;
  bit            calm          = 1'b0;   // final stretch: no idling on either side
  logic [WORD_W-1:0] last_yaw  = '0;
  logic [WORD_W-1:0] last_roll = '0;

  // Predictor state, mirrors the block
  cfg_t              model_cfg;
  int                frame_pos;
  logic [BYTE_W-1:0] asm_buf    [FRAME_N];
  logic [BYTE_W-1:0] held_frame [FRAME_N];
  logic [TICK_W-1:0] still_ticks;

  always #2 clk_i = ~clk_i;

  imu_frame_receiver_tilt_monitor DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .yaw_o           (yaw_o),
    .roll_o          (roll_o),
    .accel_o         (accel_o),
    .left_contact_o  (left_contact_o),
    .right_contact_o (right_contact_o),
    .on_ramp_o       (on_ramp_o),
    .calibrated_o    (calibrated_o),
    .frame_done_o    (frame_done_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Applies one accepted item to the predictor state and returns the reading
  // the block must report for it.
  function automatic tilt_reading_t predict_reading(input logic tick,
                                                    input logic [BYTE_W-1:0] b);
    tilt_reading_t r;
    r = '0;
    if (tick) begin
      // counter saturates rather than wrapping
      if (still_ticks != '1) still_ticks = still_ticks + 1'b1;
    end else if (frame_pos == 0) begin
      // hunting: only a byte matching under the mask starts a frame
      if ((b & model_cfg.sync_mask) == model_cfg.sync_pattern) begin
        asm_buf[HDR_POS] = b;
        frame_pos = 1;
      end
    end else begin
      // sync-looking bytes inside a frame are plain data
      asm_buf[frame_pos] = b;
      frame_pos++;
      if (frame_pos == FRAME_N) begin
        // only yaw or roll movement restarts the stability count
        if ({asm_buf[YAW_POS], asm_buf[YAW_POS+1]} !=
            {held_frame[YAW_POS], held_frame[YAW_POS+1]} ||
            {asm_buf[ROLL_POS], asm_buf[ROLL_POS+1]} !=
            {held_frame[ROLL_POS], held_frame[ROLL_POS+1]})
          still_ticks = '0;
        held_frame = asm_buf;
        frame_pos = 0;
        r.done = 1'b1;
      end
    end
    r.yaw      = {held_frame[YAW_POS], held_frame[YAW_POS+1]};
    r.roll     = {held_frame[ROLL_POS], held_frame[ROLL_POS+1]};
    r.accel    = {held_frame[ACCEL_POS], held_frame[ACCEL_POS+1]};
    r.left_ct  = held_frame[HDR_POS][0];
    r.right_ct = held_frame[HDR_POS][1];
    r.ramp     = r.roll > model_cfg.ramp_limit;
    r.calib    = still_ticks > model_cfg.stable_time;
    return r;
  endfunction

  function automatic string show_reading(input tilt_reading_t r);
    return $sformatf("yaw=%h roll=%h accel=%h lc=%b rc=%b ramp=%b cal=%b done=%b",
                     r.yaw, r.roll, r.accel, r.left_ct, r.right_ct, r.ramp,
                     r.calib, r.done);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void push_item(input logic tick, input logic [BYTE_W-1:0] b);
    sensor_items.push_back(imu_item_t'{tick, b});
    queued_total++;
  endfunction

  // Whole frame, with an optional tick slipped in before byte tick_at (-1: none)
  function automatic void push_frame(input logic [BYTE_W-1:0] hdr,
                                     input logic [WORD_W-1:0] yaw,
                                     input logic [WORD_W-1:0] roll,
                                     input logic [WORD_W-1:0] accel,
                                     input int tick_at);
    logic [BYTE_W-1:0] bytes [FRAME_N];
    bytes[HDR_POS]     = hdr;
    bytes[YAW_POS]     = yaw[15:8];
    bytes[YAW_POS+1]   = yaw[7:0];
    bytes[ROLL_POS]    = roll[15:8];
    bytes[ROLL_POS+1]  = roll[7:0];
    bytes[ACCEL_POS]   = accel[15:8];
    bytes[ACCEL_POS+1] = accel[7:0];
    for (int i = 0; i < FRAME_N; i++) begin
      if (i == tick_at) push_item(1'b1, BYTE_W'($urandom));
      push_item(1'b0, bytes[i]);
    end
  endfunction

  // Mostly well-formed frames for the current setting, with tick runs and
  // stray bytes mixed in. Repeated yaw/roll keeps the stability count alive.
  function automatic void queue_traffic(input int n);
    int target, kind, tick_at;
    logic [BYTE_W-1:0] hdr;
    target = queued_total + n;
    while (queued_total < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        hdr = (model_cfg.sync_pattern & model_cfg.sync_mask) |
              (BYTE_W'($urandom) & ~model_cfg.sync_mask);
        if ($urandom_range(2) != 0) begin
          last_yaw  = WORD_W'($urandom);
          last_roll = WORD_W'($urandom);
        end
        tick_at = ($urandom_range(9) < 7) ? -1 : $urandom_range(6, 1);
        push_frame(hdr, last_yaw, last_roll, WORD_W'($urandom), tick_at);
      end else if (kind < 72) begin
        repeat ($urandom_range(12, 1)) push_item(1'b1, BYTE_W'($urandom));
      end else if (kind < 77) begin
        repeat ($urandom_range(45, 20)) push_item(1'b1, BYTE_W'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) push_item(1'b0, BYTE_W'($urandom));
      end
    end
  endfunction

  // Setup then access phase; the register takes the data on the access edge.
  task automatic write_reg(input cfg_reg_e idx, input logic [PDATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SYNC_MASK:    model_cfg.sync_mask    = val[BYTE_W-1:0];
      REG_SYNC_PATTERN: model_cfg.sync_pattern = val[BYTE_W-1:0];
      REG_RAMP_LIMIT:   model_cfg.ramp_limit   = val[WORD_W-1:0];
      REG_STABLE_TIME:  model_cfg.stable_time  = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] mask, input logic [BYTE_W-1:0] pat,
                            input logic [WORD_W-1:0] ramp, input logic [TICK_W-1:0] stable);
    write_reg(REG_SYNC_MASK, PDATA_W'(mask));
    write_reg(REG_SYNC_PATTERN, PDATA_W'(pat));
    write_reg(REG_RAMP_LIMIT, PDATA_W'(ramp));
    write_reg(REG_STABLE_TIME, PDATA_W'(stable));
    @(negedge clk_i);
  endtask

  // Pattern mostly reachable under the mask, now and then not
  task automatic random_config();
    logic [BYTE_W-1:0] mask, pat;
    mask = BYTE_W'($urandom);
    pat  = BYTE_W'($urandom);
    if ($urandom_range(3) != 0) pat = pat & mask;
    set_config(mask, pat, WORD_W'($urandom), TICK_W'($urandom_range(40)));
  endtask

  // Wait until every item is taken and every reading has come back; one
  // result per item, so a short pause then suffices.
  task automatic drain();
    while (sensor_items.size() != 0 || in_valid_i || predicted_readings.size() != 0)
      @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Driver: presents queued items, holds them while stalled, idles in bursts.
  always @(posedge clk_i) begin
    imu_item_t item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        predicted_readings.push_back(predict_reading(mode_i, rx_byte_i));
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && sensor_items.size() != 0 && $urandom_range(7) == 0) begin
          send_gap   <= $urandom_range(5);    // start an idle burst
          in_valid_i <= 1'b0;
        end else if (sensor_items.size() != 0) begin
          item = sensor_items.pop_front();
          in_valid_i <= 1'b1;
          mode_i     <= item.tick;
          rx_byte_i  <= item.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken reading against the oldest prediction and
  // drives the output stall, including one long hold-off to back the block up.
  always @(posedge clk_i) begin
    tilt_reading_t got, want;
    string bad;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {yaw_o, roll_o, accel_o, left_contact_o, right_contact_o,
               on_ramp_o, calibrated_o, frame_done_o};
        results_seen++;
        if (predicted_readings.size() == 0) begin
          note_fault($sformatf("unexpected result %0d: %s", results_seen,
                               show_reading(got)));
        end else begin
          want = predicted_readings.pop_front();
          bad  = "";
          if (got.yaw      != want.yaw)      bad = {bad, " yaw"};
          if (got.roll     != want.roll)     bad = {bad, " roll"};
          if (got.accel    != want.accel)    bad = {bad, " accel"};
          if (got.left_ct  != want.left_ct)  bad = {bad, " left_contact"};
          if (got.right_ct != want.right_ct) bad = {bad, " right_contact"};
          if (got.ramp     != want.ramp)     bad = {bad, " on_ramp"};
          if (got.calib    != want.calib)    bad = {bad, " calibrated"};
          if (got.done     != want.done)     bad = {bad, " frame_done"};
          if (bad != "")
            note_fault($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                 results_seen, bad, show_reading(want),
                                 show_reading(got)));
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done <= 1'b1;
        hold_left     <= PRESSURE_LEN - 1;
        out_stall_i   <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(7) == 0) begin
        stall_left  <= $urandom_range(5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: any transfer on either channel or the config port resets it.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("imu_frame_receiver_tilt_monitor: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_cfg   = '{SYNC_MASK_RST, SYNC_PATTERN_RST, RAMP_LIMIT_RST, STABLE_TIME_RST};
    frame_pos   = 0;
    still_ticks = '0;
    for (int i = 0; i < FRAME_N; i++) begin
      asm_buf[i]    = '0;
      held_frame[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting, directed: tick, stray byte while hunting, a frame of all-ones
    // data with a tick mid-assembly, a frame whose data repeats the sync
    // value and roll sits exactly on the limit, then the same yaw/roll with
    // new header and accel so the count must not clear.
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'h00);
    push_frame(8'h7B, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3);
    push_frame(8'h78, 16'h7878, 16'h0011, 16'h0000, -1);
    push_frame(8'h7A, 16'h7878, 16'h0011, 16'hABCD, -1);
    queue_traffic(80);
    drain();

    // exact match, ramp at zero, calibrated after a single tick
    set_config(8'hFF, 8'hA5, 16'h0000, 32'h0000_0000);
    queue_traffic(80);
    drain();

    // every byte starts a frame, never on a ramp, never calibrated
    set_config(8'h00, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
    queue_traffic(60);
    drain();

    // pattern bits outside the mask: nothing can sync
    set_config(8'h0F, 8'hF0, 16'h8000, 32'd3);
    queue_traffic(30);
    drain();

    random_config();
    queue_traffic(90);
    drain();

    random_config();
    calm = 1'b1;
    queue_traffic(60);
    drain();

    repeat (4) @(posedge clk_i);
    if (fault_count == 0 && predicted_readings.size() == 0)
      $display("imu_frame_receiver_tilt_monitor: match");
    else
      $display("imu_frame_receiver_tilt_monitor: mismatch");
    $finish;
  end

endmodule
